// ----- hdl/skit_pkg.sv -----
// skit_pkg: shared types and helpers for the sorted key insert table
// no dependencies
`default_nettype none
package skit_pkg;
    localparam int KEY_W = 32;
    localparam int OUT_ID_W = 6;

    // sequencer states, one-hot
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SRCH  = 5'b00010,
        S_SHIFT = 5'b00100,
        S_WRITE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    // -0 becomes +0
    function automatic logic [KEY_W-1:0] canon_key(input logic [KEY_W-1:0] b);
        return (b == 32'h8000_0000) ? '0 : b;
    endfunction

    // unsigned value whose integer order is the float order
    function automatic logic [KEY_W-1:0] order_key(input logic [KEY_W-1:0] b);
        return b[KEY_W-1] ? ~b : (b | 32'h8000_0000);
    endfunction
endpackage
`default_nettype wire

// ----- hdl/skit_cmp.sv -----
// skit_cmp: shared compare unit, order test and equality of two keys
// depends on skit_pkg
`default_nettype none
module skit_cmp
    import skit_pkg::*;
(
    input  wire logic [KEY_W-1:0] i_new_key,
    input  wire logic [KEY_W-1:0] i_stored_key,
    output logic                  o_le,
    output logic                  o_eq
);
    // new key not above the stored key in float order
    assign o_le = order_key(i_new_key) <= order_key(i_stored_key);
    assign o_eq = i_new_key == i_stored_key;
endmodule
`default_nettype wire

// ----- hdl/sorted_key_insert_table.sv -----
// sorted_key_insert_table: top level, sequencer and entry memory
// depends on skit_pkg, skit_cmp
//
// usage: pulse i_start with i_key_bits and i_start_new while o_busy is low;
// the beat is taken on that edge and o_busy rises. the block scans the sorted
// table one entry a cycle through a single compare unit, then, for a new key,
// moves the later entries up one slot a cycle through the memory port and
// writes the key. the result shows on o_entry_id, o_was_present and
// o_table_full for one cycle with o_valid high, and o_busy falls with it.
// a match ends the scan at its slot; an insert scans to its slot, moves each
// later entry up one slot and then writes the key; a dropped key scans to the
// slot it would have taken (the end if none).
// the receiver cannot stall; each result is valid for exactly one cycle.
// reset empties the table (entry count to zero) and idles the sequencer;
// the memory itself is not cleared, entries at or above the count are never
// used. i_start_new empties the table before its own key is handled.
`default_nettype none
module sorted_key_insert_table
    import skit_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [KEY_W-1:0]    i_key_bits,
    input  wire logic                i_start_new,
    output logic                     o_busy,
    output logic                     o_valid,
    output logic [OUT_ID_W-1:0]      o_entry_id,
    output logic                     o_was_present,
    output logic                     o_table_full
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [KEY_W-1:0] r_keys [CAPACITY];
    logic [AW-1:0]    r_ids  [CAPACITY];

    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_pos, n_pos;
    logic [KEY_W-1:0] r_key, n_key;
    logic [KEY_W-1:0] r_rd_key;
    logic [AW-1:0]    r_rd_id;
    logic             r_valid, n_valid;
    logic [OUT_ID_W-1:0] r_id, n_id;
    logic             r_pres, n_pres, r_full, n_full;

    logic             c_le, c_eq;
    logic             mem_we;
    logic [AW-1:0]    mem_wa, mem_ra;
    logic [KEY_W-1:0] mem_wk;
    logic [AW-1:0]    mem_wid;
    logic [CW-1:0]    id_wide;

    skit_cmp u_cmp (
        .i_new_key   (r_key),
        .i_stored_key(r_rd_key),
        .o_le        (c_le),
        .o_eq        (c_eq)
    );

    // memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_keys[mem_wa] <= mem_wk;
            r_ids[mem_wa]  <= mem_wid;
        end
        r_rd_key <= r_keys[mem_ra];
        r_rd_id  <= r_ids[mem_ra];
    end

    assign id_wide = CW'(r_rd_id);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_pos   = r_pos;
        n_key   = r_key;
        n_valid = 1'b0;
        n_id    = r_id;
        n_pres  = r_pres;
        n_full  = r_full;
        mem_we  = 1'b0;
        mem_wa  = r_idx[AW-1:0];
        mem_ra  = r_idx[AW-1:0];
        mem_wk  = r_rd_key;
        mem_wid = r_rd_id;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_key = canon_key(i_key_bits);
                    if (i_start_new) n_count = '0;
                    n_idx   = '0;
                    mem_ra  = '0;
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                // r_rd_key holds entry r_idx when r_idx < count
                if (r_idx < r_count && c_le) begin
                    if (c_eq) begin
                        n_id    = OUT_ID_W'(id_wide);
                        n_pres  = 1'b1;
                        n_full  = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_pos = r_idx;
                    end
                end else if (r_idx < r_count) begin
                    n_idx  = r_idx + 1'b1;
                    mem_ra = n_idx[AW-1:0];
                end else begin
                    n_pos = r_count;
                end
                if (r_idx >= r_count || (c_le && !c_eq)) begin
                    if (r_count == CW'(CAPACITY)) begin
                        n_id    = '0;
                        n_pres  = 1'b0;
                        n_full  = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        // start move from the top entry
                        n_idx   = r_count;
                        mem_ra  = AW'(r_count - 1'b1);
                        n_state = (r_count > n_pos) ? S_SHIFT : S_WRITE;
                    end
                end
            end
            S_SHIFT: begin
                // entry r_idx-1 is on the read port, copy it up
                mem_we = 1'b1;
                mem_wa = r_idx[AW-1:0];
                n_idx  = r_idx - 1'b1;
                mem_ra = AW'(n_idx - 1'b1);
                if (n_idx == r_pos) n_state = S_WRITE;
            end
            S_WRITE: begin
                mem_we  = 1'b1;
                mem_wa  = r_pos[AW-1:0];
                mem_wk  = r_key;
                mem_wid = r_count[AW-1:0];
                n_id    = OUT_ID_W'(r_count);
                n_pres  = 1'b0;
                n_full  = 1'b0;
                n_count = r_count + 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_pos  <= n_pos;
        r_key  <= n_key;
        r_id   <= n_id;
        r_pres <= n_pres;
        r_full <= n_full;
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_entry_id    = r_id;
    assign o_was_present = r_pres;
    assign o_table_full  = r_full;
endmodule
`default_nettype wire

// ----- hdl/skit_checker.sv -----
// skit_checker: port-level checks for sorted_key_insert_table, with bind
// depends on skit_pkg
`default_nettype none
module skit_checker
    import skit_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_start,
    input wire logic                o_busy,
    input wire logic                o_valid,
    input wire logic [OUT_ID_W-1:0] o_entry_id,
    input wire logic                o_was_present,
    input wire logic                o_table_full
);
    // a result beat never claims both a match and a drop
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_was_present && o_table_full)) else $error("both flags");
    // a dropped key reports id zero
    a_drop_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_full) |-> (o_entry_id == '0)) else $error("drop id");
    // an accepted beat makes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("not busy");
    // a result comes only while the block is idle
    a_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy) else $error("result while busy");
endmodule

bind sorted_key_insert_table skit_checker u_skit_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_start      (i_start),
    .o_busy       (o_busy),
    .o_valid      (o_valid),
    .o_entry_id   (o_entry_id),
    .o_was_present(o_was_present),
    .o_table_full (o_table_full)
);
`default_nettype wire

// ----- test/sorted_key_insert_table_test.sv -----
// sorted_key_insert_table_test: self-checking bench for the sorted key insert table
// depends on skit_pkg and sorted_key_insert_table
`default_nettype none
module sorted_key_insert_table_test;
    timeunit 1ns;
    timeprecision 1ps;
    import skit_pkg::*;

    localparam int CAP = 64;
    localparam int MAX_CYCLES = 2_000_000;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             start_new;
        logic [3:0]       gap;
        logic             drain;
    } t_beat;

    typedef struct packed {
        logic [OUT_ID_W-1:0] entry_id;
        logic                was_present;
        logic                table_full;
    } t_lookup;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_start = 1'b0;
    logic [KEY_W-1:0]    i_key_bits = '0;
    logic                i_start_new = 1'b0;
    logic                o_busy;
    logic                o_valid;
    logic [OUT_ID_W-1:0] o_entry_id;
    logic                o_was_present;
    logic                o_table_full;

    sorted_key_insert_table #(.CAPACITY(CAP)) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_key_bits   (i_key_bits),
        .i_start_new  (i_start_new),
        .o_busy       (o_busy),
        .o_valid      (o_valid),
        .o_entry_id   (o_entry_id),
        .o_was_present(o_was_present),
        .o_table_full (o_table_full)
    );

    always #5 i_clk = ~i_clk;

    // shadow table used for prediction
    logic [KEY_W-1:0] tbl_keys [CAP];
    int unsigned      tbl_ids  [CAP];
    int unsigned      tbl_count = 0;

    t_beat   pending_beats[$];
    t_lookup expected_lookups[$];
    int      errors = 0;
    int      n_beats = 0;
    int      n_hits = 0;
    int      n_full = 0;
    int      n_results = 0;
    longint  cycles = 0;
    logic    stim_done = 1'b0;

    // float-order sort value; -0 folds to +0 beforehand
    function automatic logic [KEY_W-1:0] sort_value(input logic [KEY_W-1:0] k);
        return k[KEY_W-1] ? ~k : {1'b1, k[KEY_W-2:0]};
    endfunction

    // predict the lookup result of one beat and update the shadow table
    function automatic t_lookup insert_key(input logic [KEY_W-1:0] raw, input logic clr);
        logic [KEY_W-1:0] k;
        int unsigned      pos;
        logic             hit;
        t_lookup          r;
        k = (raw == 32'h8000_0000) ? '0 : raw;
        if (clr) tbl_count = 0;
        pos = tbl_count;
        hit = 1'b0;
        for (int j = 0; j < tbl_count; j++) begin
            if (sort_value(k) <= sort_value(tbl_keys[j])) begin
                pos = j;
                hit = 1'b1;
                break;
            end
        end
        if (hit && tbl_keys[pos] == k) begin
            r = '{entry_id: tbl_ids[pos][OUT_ID_W-1:0], was_present: 1'b1, table_full: 1'b0};
            return r;
        end
        if (tbl_count >= CAP) begin
            r = '{entry_id: '0, was_present: 1'b0, table_full: 1'b1};
            return r;
        end
        for (int j = tbl_count; j > pos; j--) begin
            tbl_keys[j] = tbl_keys[j-1];
            tbl_ids[j]  = tbl_ids[j-1];
        end
        tbl_keys[pos] = k;
        tbl_ids[pos]  = tbl_count;
        r = '{entry_id: tbl_count[OUT_ID_W-1:0], was_present: 1'b0, table_full: 1'b0};
        tbl_count++;
        return r;
    endfunction

    function automatic logic [3:0] draw_gap(input bit burst);
        return burst ? 4'd0 : 4'($urandom_range(0, 12));
    endfunction

    task automatic push_beat(input logic [KEY_W-1:0] k, input logic clr, input bit burst);
        pending_beats.push_back('{key: k, start_new: clr, gap: draw_gap(burst), drain: 1'b0});
    endtask

    // random key: mostly from a small pool so hits are common, some fully random
    function automatic logic [KEY_W-1:0] rand_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'd127, 23'($urandom_range(0, 15) << 19)};
        if (sel == 5) return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h0000_0000;
        if (sel == 6) return $urandom_range(0, 1) ? 32'hff80_0000 : 32'h7f80_0000;
        return $urandom;
    endfunction

    // stimulus: directed cases, a fill past capacity, then random sets
    initial begin
        bit burst;
        int set_len;
        push_beat(32'h3f80_0000, 1'b1, 1'b0);      // 1.0 into a fresh set
        push_beat(32'h0000_0000, 1'b0, 1'b0);      // +0
        push_beat(32'h8000_0000, 1'b0, 1'b0);      // -0 must match +0
        push_beat(32'hbf80_0000, 1'b0, 1'b0);      // -1.0 lands at the front
        push_beat(32'h7f80_0000, 1'b0, 1'b0);      // +inf
        push_beat(32'hff80_0000, 1'b0, 1'b0);      // -inf
        push_beat(32'h7f7f_ffff, 1'b0, 1'b0);      // largest finite
        push_beat(32'h0000_0001, 1'b0, 1'b0);      // smallest denormal
        push_beat(32'h8000_0001, 1'b0, 1'b0);      // negative denormal
        push_beat(32'h7fc0_0000, 1'b0, 1'b0);      // positive nan above +inf
        push_beat(32'hffc0_0000, 1'b0, 1'b0);      // negative nan below -inf
        push_beat(32'h7fc0_0000, 1'b0, 1'b0);      // same nan matches
        push_beat(32'h3f80_0000, 1'b0, 1'b0);      // repeat of 1.0
        push_beat(32'hffff_ffff, 1'b0, 1'b0);
        push_beat(32'h0000_0000, 1'b1, 1'b0);      // restart with +0
        push_beat(32'h8000_0000, 1'b0, 1'b0);
        pending_beats[$].drain = 1'b1;             // wait for all results first
        // fill to capacity and overflow
        for (int i = 0; i < CAP + 4; i++)
            push_beat($urandom, i == 0, i % 3 == 0);
        push_beat(pending_beats[pending_beats.size()-5].key, 1'b0, 1'b0); // hit when full
        // random sets
        while (n_beats < 800 && pending_beats.size() < 900) begin
            burst = $urandom_range(0, 3) == 0;
            set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 30);
            for (int i = 0; i < set_len; i++)
                push_beat(rand_key(), i == 0, burst);
            if ($urandom_range(0, 9) == 0) pending_beats[$].drain = 1'b1;
            if (pending_beats.size() >= 820) break;
        end
        stim_done = 1'b1;
    end

    // reset then driver: one beat per start while not busy
    int   wait_cnt = 0;
    logic holding = 1'b0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == 2) i_rst_n <= 1'b1;
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                expected_lookups.push_back(insert_key(i_key_bits, i_start_new));
                n_beats++;
            end
            if (i_start && o_busy) begin
                // keep the beat up until taken
            end else if (holding) begin
                i_start <= 1'b0;
                if (expected_lookups.size() == 0 && !(i_start && !o_busy)) holding <= 1'b0;
            end else if (wait_cnt > 0) begin
                i_start <= 1'b0;
                wait_cnt <= wait_cnt - 1;
            end else if (pending_beats.size() > 0) begin
                i_start     <= 1'b1;
                i_key_bits  <= pending_beats[0].key;
                i_start_new <= pending_beats[0].start_new;
                wait_cnt    <= pending_beats[0].gap;
                holding     <= pending_beats[0].drain;
                void'(pending_beats.pop_front());
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor: compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_lookup exp_r;
        if (i_rst_n && o_valid) begin
            n_results++;
            if (expected_lookups.size() == 0) begin
                $error("unexpected result beat id=%0d", o_entry_id);
                errors++;
            end else begin
                exp_r = expected_lookups.pop_front();
                if (exp_r.was_present) n_hits++;
                if (exp_r.table_full) n_full++;
                if (o_entry_id !== exp_r.entry_id) begin
                    $error("entry_id expected %0d got %0d", exp_r.entry_id, o_entry_id);
                    errors++;
                end
                if (o_was_present !== exp_r.was_present) begin
                    $error("was_present expected %0b got %0b", exp_r.was_present, o_was_present);
                    errors++;
                end
                if (o_table_full !== exp_r.table_full) begin
                    $error("table_full expected %0b got %0b", exp_r.table_full, o_table_full);
                    errors++;
                end
            end
        end
    end

    // end of run and timeout
    initial begin
        wait (stim_done);
        while (pending_beats.size() > 0 || i_start || expected_lookups.size() > 0) begin
            @(posedge i_clk);
            if (cycles > MAX_CYCLES) begin
                $display("timeout after %0d cycles", cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
        repeat (4 * CAP + 20) @(posedge i_clk);
        $display("%0d beats, %0d results: %0d repeated keys, %0d drops on a full table",
                 n_beats, n_results, n_hits, n_full);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
hdl/skit_pkg.sv
hdl/skit_cmp.sv
hdl/sorted_key_insert_table.sv
hdl/skit_checker.sv
test/sorted_key_insert_table_test.sv
